[hw/rtl/kea_pkg.sv]
// Shared types and constants for the Kruskal edge acceptor.
// No dependencies; imported by kruskal_edge_acceptor.
package kea_pkg;

    localparam int NUM_VERTICES = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int LABEL_W      = $clog2(NUM_VERTICES);
    localparam int COUNT_W      = $clog2(NUM_VERTICES + 1);

    typedef logic [LABEL_W-1:0]     vertex_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAIL,
        ST_WALK,
        ST_RESULT
    } state_t;

endpackage

[hw/rtl/kruskal_edge_acceptor.sv]
// Kruskal edge acceptor: per-vertex component labels in a RAM, relabel walk.
// Depends on kea_pkg and kea_ram.
//
// One edge is taken per beat and gives one result beat. An edge with an index
// not below the vertex count goes from acceptance straight to the result state;
// an edge whose ends already share a component first passes the head and tail
// label reads; an accepted edge also runs the relabel walk, which reads every
// label below the vertex count, capped at 64, once through the single RAM read
// port (one label per cycle, write-back in the cycle after the read). The
// result is loaded once the output register is free; the next edge can be taken
// in the cycle after. A new edge is taken while the previous result still waits
// in the output register. Labels come out of reset and out of a last edge as
// identity at once: a valid bit per vertex marks a RAM entry as written, and an
// entry not yet written reads as its own index.
module kruskal_edge_acceptor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  kea_pkg::vertex_t head_vertex,
    input  kea_pkg::vertex_t tail_vertex,
    input  kea_pkg::weight_t edge_weight,
    input  logic             last_edge,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             accepted,
    output kea_pkg::vertex_t out_head,
    output kea_pkg::vertex_t out_tail,
    output kea_pkg::weight_t out_weight,
    output logic             bad_vertex,
    output logic             done_res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  kea_pkg::count_t  cfg_data
);

    import kea_pkg::*;

    state_t  state_reg, state_next;
    count_t  vcount_reg;
    count_t  count_eff;

    vertex_t head_reg, head_next;
    vertex_t tail_reg, tail_next;
    weight_t weight_reg, weight_next;
    logic    last_reg, last_next;
    logic    bad_reg, bad_next;
    logic    acc_reg, acc_next;
    vertex_t head_comp_reg, head_comp_next;
    vertex_t tail_comp_reg, tail_comp_next;
    count_t  rd_idx_reg, rd_idx_next;
    logic    pend_reg, pend_next;
    vertex_t raddr_d_reg;
    logic [NUM_VERTICES-1:0] valid_reg, valid_next;

    logic    out_valid_reg, out_valid_next;
    logic    o_acc_reg, o_acc_next;
    vertex_t o_head_reg, o_head_next;
    vertex_t o_tail_reg, o_tail_next;
    weight_t o_weight_reg, o_weight_next;
    logic    o_bad_reg, o_bad_next;
    logic    o_done_reg, o_done_next;

    logic    ram_re;
    vertex_t ram_raddr;
    vertex_t ram_rdata;
    logic    ram_we;
    vertex_t lbl_rd;
    logic    in_bad;

    kea_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (NUM_VERTICES)
    ) u_labels (
        .clk   (clk),
        .we    (ram_we),
        .waddr (raddr_d_reg),
        .wdata (head_comp_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_eff = (vcount_reg > count_t'(NUM_VERTICES)) ? count_t'(NUM_VERTICES)
                                                             : vcount_reg;
    assign in_bad    = (count_t'(head_vertex) >= count_eff) ||
                       (count_t'(tail_vertex) >= count_eff);

    // Label of the entry read last cycle; unwritten entries hold identity.
    assign lbl_rd = valid_reg[raddr_d_reg] ? ram_rdata : raddr_d_reg;

    // Walk write-back lands in the cycle after the read, so no entry is read after its write.
    assign ram_we = (state_reg == ST_WALK) && pend_reg && (lbl_rd == tail_comp_reg);

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign accepted   = o_acc_reg;
    assign out_head   = o_head_reg;
    assign out_tail   = o_tail_reg;
    assign out_weight = o_weight_reg;
    assign bad_vertex = o_bad_reg;
    assign done_res   = o_done_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_bad ? ST_RESULT : ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                state_next = (lbl_rd != head_comp_reg) ? ST_WALK : ST_RESULT;
            end
            ST_WALK:
            begin
                if ((rd_idx_reg >= count_eff) && !pend_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        acc_next       = acc_reg;
        head_comp_next = head_comp_reg;
        tail_comp_next = tail_comp_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        o_acc_next     = o_acc_reg;
        o_head_next    = o_head_reg;
        o_tail_next    = o_tail_reg;
        o_weight_next  = o_weight_reg;
        o_bad_next     = o_bad_reg;
        o_done_next    = o_done_reg;
        ram_re         = 1'b0;
        ram_raddr      = head_vertex;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ram_we)
        begin
            valid_next[raddr_d_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    head_next   = head_vertex;
                    tail_next   = tail_vertex;
                    weight_next = edge_weight;
                    last_next   = last_edge;
                    bad_next    = in_bad;
                    acc_next    = 1'b0;
                    ram_re      = !in_bad;
                    ram_raddr   = head_vertex;
                end
            end
            ST_HEAD:
            begin
                head_comp_next = lbl_rd;
                ram_re         = 1'b1;
                ram_raddr      = tail_reg;
            end
            ST_TAIL:
            begin
                tail_comp_next = lbl_rd;
                if (lbl_rd != head_comp_reg)
                begin
                    acc_next    = 1'b1;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (rd_idx_reg < count_eff)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[LABEL_W-1:0];
                    rd_idx_next = rd_idx_reg + count_t'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_acc_next     = acc_reg;
                    o_head_next    = head_reg;
                    o_tail_next    = tail_reg;
                    o_weight_next  = weight_reg;
                    o_bad_next     = bad_reg;
                    o_done_next    = last_reg;
                    if (last_reg)
                    begin
                        valid_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= count_t'(NUM_VERTICES);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            rd_idx_reg    <= rd_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        weight_reg    <= weight_next;
        last_reg      <= last_next;
        bad_reg       <= bad_next;
        acc_reg       <= acc_next;
        head_comp_reg <= head_comp_next;
        tail_comp_reg <= tail_comp_next;
        o_acc_reg     <= o_acc_next;
        o_head_reg    <= o_head_next;
        o_tail_reg    <= o_tail_next;
        o_weight_reg  <= o_weight_next;
        o_bad_reg     <= o_bad_next;
        o_done_reg    <= o_done_next;
        if (ram_re)
        begin
            raddr_d_reg <= ram_raddr;
        end
    end

endmodule

[hw/rtl/kea_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for kruskal_edge_acceptor: edge and config beats in, one result per edge.
// Depends on kea_pkg (hw/rtl/kea_pkg.sv) and the acceptor RTL.
module tb_top;

    import kea_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 320;
    localparam int RANDOM_GOAL = 630;

    typedef struct {
        vertex_t head;
        vertex_t tail;
        weight_t weight;
        logic    last;
    } graph_edge_t;

    typedef struct {
        logic    acc;
        vertex_t head;
        vertex_t tail;
        weight_t weight;
        logic    bad;
        logic    done;
    } mst_result_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    vertex_t head_vertex = '0;
    vertex_t tail_vertex = '0;
    weight_t edge_weight = '0;
    logic    last_edge = 1'b0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    logic    accepted;
    vertex_t out_head;
    vertex_t out_tail;
    weight_t out_weight;
    logic    bad_vertex;
    logic    done_res;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    count_t  cfg_data = '0;

    // predictor state
    vertex_t comp_label [NUM_VERTICES];
    count_t  vcount;

    graph_edge_t edge_q[$];
    mst_result_t result_q[$];

    int   sent_total = 0;
    int   checked_total = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    int   in_gap = 0;
    int   out_wait = 0;
    int   hold_req = 0;
    int   hold_ack = 0;
    bit   in_calm = 1'b0;
    bit   out_calm = 1'b0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    logic cfg_took = 1'b0;

    kruskal_edge_acceptor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .head_vertex(head_vertex),
        .tail_vertex(tail_vertex),
        .edge_weight(edge_weight),
        .last_edge  (last_edge),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .out_head   (out_head),
        .out_tail   (out_tail),
        .out_weight (out_weight),
        .bad_vertex (bad_vertex),
        .done_res   (done_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void labels_to_identity();
        int v;
        for (v = 0; v < NUM_VERTICES; v++)
            comp_label[v] = vertex_t'(v);
    endfunction

    function automatic int unsigned live_vertices(count_t c);
        return (c > NUM_VERTICES) ? NUM_VERTICES : c;
    endfunction

    // Union step: merge tail's component into head's, walk limited to live vertices.
    function automatic mst_result_t join_edge(graph_edge_t e);
        mst_result_t r;
        int unsigned n;
        int unsigned v;
        vertex_t hc;
        vertex_t tc;
        n = live_vertices(vcount);
        r.acc = 1'b0;
        r.bad = 1'b0;
        r.head = e.head;
        r.tail = e.tail;
        r.weight = e.weight;
        r.done = e.last;
        if (e.head >= n || e.tail >= n)
            r.bad = 1'b1;
        else
        begin
            hc = comp_label[e.head];
            tc = comp_label[e.tail];
            if (hc != tc)
            begin
                r.acc = 1'b1;
                for (v = 0; v < n; v++)
                    if (comp_label[v] == tc)
                        comp_label[v] = hc;
            end
        end
        if (e.last)
            labels_to_identity();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Monitor and predictor: results checked before the edge of the same beat is predicted.
    always @(posedge clk)
    begin
        mst_result_t want;
        graph_edge_t e;
        in_took <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        cfg_took <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("result beat with nothing pending (head)", out_head, 0);
                else
                begin
                    want = result_q.pop_front();
                    checked_total++;
                    if (accepted !== want.acc)
                        report_mismatch("accepted", accepted, want.acc);
                    if (out_head !== want.head)
                        report_mismatch("out_head", out_head, want.head);
                    if (out_tail !== want.tail)
                        report_mismatch("out_tail", out_tail, want.tail);
                    if (out_weight !== want.weight)
                        report_mismatch("out_weight", out_weight, want.weight);
                    if (bad_vertex !== want.bad)
                        report_mismatch("bad_vertex", bad_vertex, want.bad);
                    if (done_res !== want.done)
                        report_mismatch("done_res", done_res, want.done);
                end
            end
            if (in_valid && in_ready)
            begin
                e.head = head_vertex;
                e.tail = tail_vertex;
                e.weight = edge_weight;
                e.last = last_edge;
                result_q.push_back(join_edge(e));
            end
            if (cfg_valid && cfg_ready)
                vcount = cfg_data;
        end
    end

    // Edge driver: one beat held until taken, random gap before the next.
    always @(negedge clk)
    begin
        logic nv;
        graph_edge_t e;
        nv = in_valid;
        if (in_valid && in_took)
        begin
            nv = 1'b0;
            in_gap = in_calm ? 0 : $urandom_range(0, 11);
        end
        if (!nv && rst_n)
        begin
            if (in_gap != 0)
                in_gap--;
            else if (edge_q.size() != 0)
            begin
                e = edge_q.pop_front();
                nv = 1'b1;
                head_vertex <= e.head;
                tail_vertex <= e.tail;
                edge_weight <= e.weight;
                last_edge <= e.last;
            end
        end
        in_valid <= nv;
    end

    // Result sink: random stall after each beat, plus a long hold on request.
    always @(negedge clk)
    begin
        if (out_ready && out_took)
            out_wait = out_calm ? 0 : $urandom_range(0, 11);
        if (hold_ack != hold_req)
        begin
            hold_ack = hold_req;
            out_wait = LONG_HOLD;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_wait != 0)
        begin
            out_wait--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    task automatic queue_edge(int unsigned h, int unsigned t, int unsigned w, bit last);
        graph_edge_t e;
        e.head = vertex_t'(h);
        e.tail = vertex_t'(t);
        e.weight = weight_t'(w);
        e.last = last;
        edge_q.push_back(e);
        sent_total++;
    endtask

    task automatic drain_results();
        while (checked_total != sent_total)
            @(negedge clk);
    endtask

    task automatic write_count(int unsigned c);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= count_t'(c);
        @(negedge clk);
        while (!cfg_took)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly live vertices, now and then one at or beyond the count
    function automatic int unsigned pick_vertex(int unsigned n);
        if (n == 0)
            return $urandom_range(0, 63);
        if (n < NUM_VERTICES && $urandom_range(0, 15) == 0)
            return $urandom_range(n, 63);
        return $urandom_range(0, n - 1);
    endfunction

    // One graph's edge list with nondecreasing weights; last beat marked if closed.
    task automatic queue_graph(int unsigned n, bit closed);
        int unsigned cnt;
        int unsigned i;
        int unsigned w;
        cnt = (n == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2 * n + 2);
        w = $urandom_range(0, 65535 - 4 * cnt);
        for (i = 0; i < cnt; i++)
        begin
            queue_edge(pick_vertex(n), pick_vertex(n), w, closed && (i == cnt - 1));
            w += $urandom_range(0, 3);
        end
    endtask

    initial
    begin
        int unsigned c;
        int unsigned n;
        int unsigned g;
        int unsigned i;
        labels_to_identity();
        vcount = count_t'(NUM_VERTICES);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: joins, repeats, self loop, extremes, reset by last edge
        write_count(64);
        queue_edge(0, 63, 16'h0000, 0);
        queue_edge(63, 0, 16'h0001, 0);
        queue_edge(5, 5, 16'h0002, 0);
        queue_edge(1, 2, 16'h0010, 0);
        queue_edge(2, 0, 16'h0010, 0);
        queue_edge(63, 1, 16'h0011, 0);
        queue_edge(42, 21, 16'h7fff, 0);
        queue_edge(21, 42, 16'h8000, 0);
        queue_edge(62, 61, 16'hffff, 1);
        queue_edge(0, 63, 16'hffff, 0);
        queue_edge(10, 40, 16'hffff, 0);
        drain_results();
        // shrink mid-graph: vertex 40 lies outside the walk and keeps its label
        write_count(20);
        queue_edge(5, 10, 16'h0100, 0);
        drain_results();
        write_count(64);
        queue_edge(40, 5, 16'h0101, 1);
        drain_results();
        write_count(1);
        queue_edge(0, 0, 16'h0003, 0);
        queue_edge(0, 1, 16'h0004, 0);
        queue_edge(1, 0, 16'h0005, 1);
        drain_results();
        write_count(0);
        queue_edge(0, 0, 16'h0000, 0);
        queue_edge(63, 63, 16'hffff, 1);
        drain_results();
        write_count(127);
        queue_edge(63, 0, 16'h1234, 0);
        queue_edge(0, 63, 16'habcd, 1);
        drain_results();
        write_count(2);
        queue_edge(0, 1, 16'h0020, 0);
        queue_edge(1, 0, 16'h0021, 0);
        queue_edge(0, 2, 16'h0022, 1);
        queue_edge(1, 0, 16'h0023, 0);
        drain_results();
        write_count(8);
        queue_edge(1, 0, 16'h0030, 0);
        queue_edge(7, 0, 16'h0031, 0);
        queue_edge(7, 1, 16'h0032, 1);
        drain_results();

        // receiver holds off while the sender keeps offering
        in_calm = 1'b1;
        write_count(4);
        hold_req++;
        for (i = 0; i < 40; i++)
            queue_edge($urandom_range(0, 3), $urandom_range(0, 3), 100 + i, i == 39);
        drain_results();
        in_calm = 1'b0;

        while (sent_total < 60 + RANDOM_GOAL)
        begin
            case ($urandom_range(0, 15))
                0, 1:    c = 64;
                2:       c = $urandom_range(65, 127);
                3:       c = 0;
                4:       c = $urandom_range(13, 63);
                default: c = $urandom_range(1, 12);
            endcase
            n = live_vertices(count_t'(c));
            in_calm = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            write_count(c);
            for (g = $urandom_range(1, 3); g != 0; g--)
                queue_graph(n, 1'b1);
            // open graph: labels carry into the next count
            if ($urandom_range(0, 3) == 0)
                queue_graph(n, 1'b0);
            for (i = $urandom_range(0, 4); i != 0; i--)
                queue_edge($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 65535), $urandom_range(0, 3) == 0);
            drain_results();
        end

        repeat (80) @(posedge clk);
        if (result_q.size() != 0)
            report_mismatch("results never delivered", result_q.size(), 0);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
